// ===== rtl/ihc_pkg.sv =====
// Package for the IPv4 L4 header classifier.
// Holds item structs, field offsets, status and family codes.
// No dependencies.
`default_nettype none

package ihc_pkg;

    localparam int HEADER_WINDOW = 80;
    localparam int LENGTH_BITS   = 17;
    localparam int TOT_W         = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

    localparam int FIXED_BYTES = 40;
    localparam int FIX_IW      = $clog2(FIXED_BYTES);

    localparam logic [2:0] ST_VALID       = 3'd0;
    localparam logic [2:0] ST_IPV6        = 3'd1;
    localparam logic [2:0] ST_MALFORMED   = 3'd2;
    localparam logic [2:0] ST_FRAGMENT    = 3'd3;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

    localparam logic [2:0] FAM_NONE = 3'd0;
    localparam logic [2:0] FAM_IPV4 = 3'd4;
    localparam logic [2:0] FAM_IPV6 = 3'd6;

    localparam logic [3:0]  VER_IPV4      = 4'd4;
    localparam logic [3:0]  VER_IPV6      = 4'd6;
    localparam logic [7:0]  IHL_MASK      = 8'h0f;
    localparam logic [15:0] FRAG_MF_BIT   = 16'h2000;
    localparam logic [15:0] FRAG_OFS_MASK = 16'h1fff;
    localparam logic [15:0] TCP_RST_BIT   = 16'h0004;
    localparam logic [6:0]  IHL_MAX_BYTES = 7'd60;
    localparam logic [6:0]  IP_MIN_HDR    = 7'd20;
    localparam logic [6:0]  TCP_MIN_HDR   = 7'd20;
    localparam logic [6:0]  UDP_MIN_HDR   = 7'd8;
    localparam int          IPV6_MIN_LEN  = 40;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;

    localparam int OFS_SPORT_HI = 0;
    localparam int OFS_SPORT_LO = 1;
    localparam int OFS_DPORT_HI = 2;
    localparam int OFS_DPORT_LO = 3;
    localparam int OFS_ULEN_HI  = 4;
    localparam int OFS_ULEN_LO  = 5;
    localparam int OFS_TOF_HI   = 12;
    localparam int OFS_TOF_LO   = 13;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       gso_multi;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  family;
        logic [7:0]  protocol;
        logic [63:0] src_addr_hi;
        logic [63:0] src_addr_lo;
        logic [63:0] dst_addr_hi;
        logic [63:0] dst_addr_lo;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic        rst_flag;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/ipv4_l4_header_classifier.sv =====
// Top level of the IPv4 L4 header classifier.
// Depends on ihc_pkg for item structs, offsets and codes.
//
// Takes a packet one byte item per cycle and gives one classification item per
// packet: its last byte sets r_pend, which loads the output register when free.
// Bytes 0..39 and the transport ports, UDP length and TCP data offset word are
// captured into registers as they pass, so no header memory is read at classify
// time; combinational compare logic fills the output register. The input stalls
// only while a finished classification waits and the output register is held,
// so the sustained rate is one byte per cycle. The length count saturates.
`default_nettype none

module ipv4_l4_header_classifier
    import ihc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out
);

    localparam logic [LENGTH_BITS-1:0] CNT_MAX = {LENGTH_BITS{1'b1}};

    logic [LENGTH_BITS-1:0] r_cnt, n_cnt;
    logic [LENGTH_BITS-1:0] r_len;
    logic                   r_gso;
    logic                   r_pend;
    logic [7:0]             r_hdr [FIXED_BYTES];
    logic [15:0]            r_sport, r_dport, r_ulen, r_tof;
    logic                   r_out_valid;
    t_out_item              r_out;
    t_out_item              cls;

    logic                   out_free;
    logic                   in_acc;
    logic [3:0]             cap_ihl;
    logic [LENGTH_BITS-1:0] l4_off;
    logic                   in_win;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_pend && !out_free;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign n_cnt   = (r_cnt < CNT_MAX) ? r_cnt + 1'b1 : r_cnt;
    assign cap_ihl = (r_cnt == '0) ? i_in.data_byte[3:0] : r_hdr[0][3:0];
    assign l4_off  = r_cnt - LENGTH_BITS'({cap_ihl, 2'b00});
    assign in_win  = r_cnt < LENGTH_BITS'(HEADER_WINDOW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_pend <= 1'b0;
        end else begin
            if (in_acc) begin
                r_cnt <= i_in.last_byte ? '0 : n_cnt;
            end
            if (in_acc && i_in.last_byte) begin
                r_pend <= 1'b1;
            end else if (out_free) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (r_cnt < LENGTH_BITS'(FIXED_BYTES)) begin
                r_hdr[r_cnt[FIX_IW-1:0]] <= i_in.data_byte;
            end
            if (in_win) begin
                unique case (l4_off)
                    LENGTH_BITS'(OFS_SPORT_HI): r_sport[15:8] <= i_in.data_byte;
                    LENGTH_BITS'(OFS_SPORT_LO): r_sport[7:0]  <= i_in.data_byte;
                    LENGTH_BITS'(OFS_DPORT_HI): r_dport[15:8] <= i_in.data_byte;
                    LENGTH_BITS'(OFS_DPORT_LO): r_dport[7:0]  <= i_in.data_byte;
                    LENGTH_BITS'(OFS_ULEN_HI):  r_ulen[15:8]  <= i_in.data_byte;
                    LENGTH_BITS'(OFS_ULEN_LO):  r_ulen[7:0]   <= i_in.data_byte;
                    LENGTH_BITS'(OFS_TOF_HI):   r_tof[15:8]   <= i_in.data_byte;
                    LENGTH_BITS'(OFS_TOF_LO):   r_tof[7:0]    <= i_in.data_byte;
                    default: ;
                endcase
            end
            if (i_in.last_byte) begin
                r_len <= n_cnt;
                r_gso <= i_in.gso_multi;
            end
        end
    end

    logic [3:0]       ver;
    logic [6:0]       hl;
    logic [6:0]       thl;
    logic [TOT_W:0]   len_x, tot_raw, tot, hl_x;
    logic [15:0]      frag;
    logic [7:0]       proto;

    always_comb begin
        ver     = r_hdr[0][7:4];
        hl      = 7'({r_hdr[0] & IHL_MASK, 2'b00});
        thl     = {1'b0, r_tof[15:12], 2'b00};
        len_x   = (TOT_W+1)'(r_len);
        tot_raw = (TOT_W+1)'({r_hdr[2], r_hdr[3]});
        hl_x    = (TOT_W+1)'(hl);
        proto   = r_hdr[9];
        frag    = {r_hdr[6], r_hdr[7]};
        if (proto == PROTO_TCP && r_gso && tot_raw < hl_x + (TOT_W+1)'(TCP_MIN_HDR)) begin
            tot = len_x;
        end else begin
            tot = tot_raw;
        end

        cls        = '0;
        cls.status = ST_MALFORMED;
        if (r_len != '0) begin
            if (ver == VER_IPV6) begin
                if (len_x >= (TOT_W+1)'(IPV6_MIN_LEN)) begin
                    cls.status      = ST_IPV6;
                    cls.family      = FAM_IPV6;
                    cls.protocol    = r_hdr[6];
                    cls.src_addr_hi = {r_hdr[8],  r_hdr[9],  r_hdr[10], r_hdr[11],
                                       r_hdr[12], r_hdr[13], r_hdr[14], r_hdr[15]};
                    cls.src_addr_lo = {r_hdr[16], r_hdr[17], r_hdr[18], r_hdr[19],
                                       r_hdr[20], r_hdr[21], r_hdr[22], r_hdr[23]};
                    cls.dst_addr_hi = {r_hdr[24], r_hdr[25], r_hdr[26], r_hdr[27],
                                       r_hdr[28], r_hdr[29], r_hdr[30], r_hdr[31]};
                    cls.dst_addr_lo = {r_hdr[32], r_hdr[33], r_hdr[34], r_hdr[35],
                                       r_hdr[36], r_hdr[37], r_hdr[38], r_hdr[39]};
                end
            end else if (ver == VER_IPV4 && len_x >= (TOT_W+1)'(IP_MIN_HDR)) begin
                if (!(hl < IP_MIN_HDR || hl > IHL_MAX_BYTES || tot < hl_x || tot > len_x)) begin
                    cls.family      = FAM_IPV4;
                    cls.protocol    = proto;
                    cls.src_addr_lo = {32'd0, r_hdr[12], r_hdr[13], r_hdr[14], r_hdr[15]};
                    cls.dst_addr_lo = {32'd0, r_hdr[16], r_hdr[17], r_hdr[18], r_hdr[19]};
                    priority if ((frag & (FRAG_MF_BIT | FRAG_OFS_MASK)) != '0) begin
                        cls.status = ST_FRAGMENT;
                    end else if (proto == PROTO_TCP) begin
                        if (tot >= hl_x + (TOT_W+1)'(TCP_MIN_HDR) && thl >= TCP_MIN_HDR
                            && (TOT_W+1)'(thl) + hl_x <= tot) begin
                            cls.status   = ST_VALID;
                            cls.src_port = r_sport;
                            cls.dst_port = r_dport;
                            cls.rst_flag = (r_tof & TCP_RST_BIT) != '0;
                        end
                    end else if (proto == PROTO_UDP) begin
                        if (tot >= hl_x + (TOT_W+1)'(UDP_MIN_HDR)
                            && r_ulen >= 16'(UDP_MIN_HDR)
                            && (TOT_W+1)'(r_ulen) + hl_x <= tot) begin
                            cls.status   = ST_VALID;
                            cls.src_port = r_sport;
                            cls.dst_port = r_dport;
                        end
                    end else begin
                        cls.status = ST_UNSUPPORTED;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pend && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend && out_free) begin
            r_out <= cls;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ihc_checker.sv =====
// Port-level checker for the IPv4 L4 header classifier.
// Depends on ihc_pkg; bound to the top level at the end of this file.
`default_nettype none

module ihc_checker
    import ihc_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_item  i_in,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("held item changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in.last_byte && !o_out_valid |-> ##2 o_out_valid)
        else $error("no result after last byte");

    a_ports_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != ST_VALID |->
            o_out.src_port == '0 && o_out.dst_port == '0 && !o_out.rst_flag)
        else $error("ports set on non-valid item");

    a_valid_family: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_VALID |-> o_out.family == FAM_IPV4)
        else $error("valid item without IPv4 family");

endmodule

bind ipv4_l4_header_classifier ihc_checker u_ihc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

`default_nettype wire

// ===== bench/tb_ipv4_l4_header_classifier.sv =====
// Testbench for ipv4_l4_header_classifier: directed and random packets, with every verdict
// checked field by field against a cycle-free classifier written here.
// Depends on ihc_pkg and the ipv4_l4_header_classifier RTL.
`timescale 1ns / 100ps

module tb_ipv4_l4_header_classifier
    import ihc_pkg::*;
();

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_BYTES = 300;
    localparam int RANDOM_PACKETS = 12;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out;

    logic [7:0]             header_copy [HEADER_WINDOW];
    logic [LENGTH_BITS-1:0] byte_tally;
    t_out_item              verdict_q [$];
    logic [7:0]             frame_bytes [$];
    t_out_item              want;
    bit                     quiet = 1'b0;
    int                     n_errors = 0;
    int                     cycle_cnt = 0;
    int                     random_bytes_sent = 0;

    ipv4_l4_header_classifier u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_ipv4_l4_header_classifier failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < 16);
    end

    function automatic logic [7:0] hdr_byte(int unsigned idx);
        if (idx >= HEADER_WINDOW) return 8'h00;
        return header_copy[idx];
    endfunction

    function automatic logic [15:0] hdr_word16(int unsigned idx);
        return {hdr_byte(idx), hdr_byte(idx + 1)};
    endfunction

    function automatic logic [31:0] hdr_word32(int unsigned idx);
        return {hdr_word16(idx), hdr_word16(idx + 2)};
    endfunction

    function automatic logic [63:0] hdr_word64(int unsigned idx);
        return {hdr_word32(idx), hdr_word32(idx + 4)};
    endfunction

    function automatic t_out_item classify_packet(int unsigned len, bit gso);
        t_out_item   r;
        int unsigned ver;
        int unsigned hl;
        int unsigned total;
        int unsigned proto;
        int unsigned frag;
        int unsigned tcp_word;
        int unsigned thl;
        int unsigned ulen;
        r = '0;
        r.status = ST_MALFORMED;
        if (len < 1) return r;
        ver = hdr_byte(0) >> 4;
        if (ver == VER_IPV6) begin
            if (len < IPV6_MIN_LEN) return r;
            r.status = ST_IPV6;
            r.family = FAM_IPV6;
            r.protocol = hdr_byte(6);
            r.src_addr_hi = hdr_word64(8);
            r.src_addr_lo = hdr_word64(16);
            r.dst_addr_hi = hdr_word64(24);
            r.dst_addr_lo = hdr_word64(32);
            return r;
        end
        if (ver != VER_IPV4 || len < IP_MIN_HDR) return r;
        hl = (hdr_byte(0) & IHL_MASK) * 4;
        total = hdr_word16(2);
        proto = hdr_byte(9);
        if (proto == PROTO_TCP && gso && total < hl + TCP_MIN_HDR) total = len;
        if (hl < IP_MIN_HDR || hl > IHL_MAX_BYTES || total < hl || total > len) return r;
        r.family = FAM_IPV4;
        r.protocol = hdr_byte(9);
        r.src_addr_lo = 64'(hdr_word32(12));
        r.dst_addr_lo = 64'(hdr_word32(16));
        frag = hdr_word16(6);
        if ((frag & (FRAG_MF_BIT | FRAG_OFS_MASK)) != 0) begin
            r.status = ST_FRAGMENT;
            return r;
        end
        if (proto == PROTO_TCP) begin
            if (total < hl + TCP_MIN_HDR) return r;
            tcp_word = hdr_word16(hl + OFS_TOF_HI);
            thl = (tcp_word >> 12) * 4;
            if (thl < TCP_MIN_HDR || thl > total - hl) return r;
            r.status = ST_VALID;
            r.src_port = hdr_word16(hl + OFS_SPORT_HI);
            r.dst_port = hdr_word16(hl + OFS_DPORT_HI);
            r.rst_flag = (tcp_word & TCP_RST_BIT) != 0;
            return r;
        end
        if (proto == PROTO_UDP) begin
            if (total < hl + UDP_MIN_HDR) return r;
            ulen = hdr_word16(hl + OFS_ULEN_HI);
            if (ulen < UDP_MIN_HDR || ulen > total - hl) return r;
            r.status = ST_VALID;
            r.src_port = hdr_word16(hl + OFS_SPORT_HI);
            r.dst_port = hdr_word16(hl + OFS_DPORT_HI);
            return r;
        end
        r.status = ST_UNSUPPORTED;
        return r;
    endfunction

    task automatic track_byte(input t_in_item item);
        int unsigned len;
        if (byte_tally < HEADER_WINDOW) header_copy[byte_tally] = item.data_byte;
        if (byte_tally != '1) byte_tally = byte_tally + 1'b1;
        if (item.last_byte) begin
            len = byte_tally;
            byte_tally = '0;
            verdict_q.push_back(classify_packet(len, item.gso_multi));
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_q.size() == 0) begin
                $error("verdict with none pending: status %0d", o_out.status);
                n_errors++;
            end else begin
                want = verdict_q.pop_front();
                check_field("status", 64'(want.status), 64'(o_out.status));
                check_field("family", 64'(want.family), 64'(o_out.family));
                check_field("protocol", 64'(want.protocol), 64'(o_out.protocol));
                check_field("src_addr_hi", want.src_addr_hi, o_out.src_addr_hi);
                check_field("src_addr_lo", want.src_addr_lo, o_out.src_addr_lo);
                check_field("dst_addr_hi", want.dst_addr_hi, o_out.dst_addr_hi);
                check_field("dst_addr_lo", want.dst_addr_lo, o_out.dst_addr_lo);
                check_field("src_port", 64'(want.src_port), 64'(o_out.src_port));
                check_field("dst_port", 64'(want.dst_port), 64'(o_out.dst_port));
                check_field("rst_flag", 64'(want.rst_flag), 64'(o_out.rst_flag));
            end
        end
    end

    task automatic push_byte(input t_in_item item);
        while (!quiet && ($urandom_range(99) < 16)) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        track_byte(item);
        random_bytes_sent++;
    endtask

    task automatic wait_for_verdicts();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_packet(input bit gso, input int extra);
        t_in_item item;
        int       n;
        n = frame_bytes.size() + extra;
        for (int i = 0; i < n; i++) begin
            item.data_byte = (i < frame_bytes.size()) ? frame_bytes[i] : 8'($urandom_range(255));
            item.last_byte = (i == n - 1);
            item.gso_multi = item.last_byte ? gso : 1'($urandom_range(1));
            push_byte(item);
        end
    endtask

    task automatic put16(input int idx, input logic [15:0] v);
        frame_bytes[idx] = v[15:8];
        frame_bytes[idx + 1] = v[7:0];
    endtask

    task automatic set_version(input logic [3:0] ver);
        frame_bytes[0] = {ver, frame_bytes[0][3:0]};
    endtask

    task automatic build_raw(input int n);
        frame_bytes.delete();
        repeat (n) frame_bytes.push_back(8'($urandom_range(255)));
    endtask

    task automatic build_ipv4(input int ihl, input logic [7:0] proto, input int l4_len);
        int hlen;
        int total;
        int hi;
        hlen = ihl * 4;
        total = hlen + l4_len;
        build_raw((total < 20) ? 20 : total);
        frame_bytes[0] = {VER_IPV4, 4'(ihl)};
        put16(2, 16'(total));
        put16(6, {frame_bytes[6], frame_bytes[7]} & ~(FRAG_MF_BIT | FRAG_OFS_MASK));
        frame_bytes[9] = proto;
        if (proto == PROTO_TCP && l4_len >= TCP_MIN_HDR) begin
            hi = l4_len / 4;
            if (hi > 15) hi = 15;
            frame_bytes[hlen + OFS_TOF_HI] = {4'($urandom_range(hi, 5)),
                                              frame_bytes[hlen + OFS_TOF_HI][3:0]};
        end
        if (proto == PROTO_UDP && l4_len >= UDP_MIN_HDR)
            put16(hlen + OFS_ULEN_HI, 16'($urandom_range(l4_len, 8)));
    endtask

    task automatic fill_addresses(input logic [7:0] v);
        for (int i = 12; i < 20; i++) frame_bytes[i] = v;
    endtask

    task automatic test_short_packets();
        build_raw(1);
        frame_bytes[0] = 8'hff;
        send_packet(1'b1, 0);
        build_raw(1);
        frame_bytes[0] = 8'h00;
        send_packet(1'b0, 0);
        build_ipv4(5, PROTO_TCP, 20);
        set_version(4'hf);
        send_packet(1'b0, 0);
        build_ipv4(5, PROTO_UDP, 8);
        set_version(4'h0);
        send_packet(1'b1, 0);
        build_ipv4(5, PROTO_UDP, 0);
        void'(frame_bytes.pop_back());
        send_packet(1'b0, 0);
    endtask

    task automatic test_ipv6();
        build_raw(39);
        set_version(VER_IPV6);
        send_packet(1'b0, 0);
        build_raw(40);
        for (int i = 0; i < 40; i++) frame_bytes[i] = 8'hff;
        set_version(VER_IPV6);
        send_packet(1'b1, 0);
        build_raw(40);
        for (int i = 0; i < 40; i++) frame_bytes[i] = 8'h00;
        set_version(VER_IPV6);
        send_packet(1'b0, 0);
        build_raw(64);
        set_version(VER_IPV6);
        send_packet(1'b0, 0);
    endtask

    task automatic test_ip_header();
        build_ipv4(4, PROTO_UDP, 20);
        send_packet(1'b0, 0);
        build_ipv4(0, PROTO_TCP, 40);
        send_packet(1'b1, 0);
        build_ipv4(15, PROTO_UDP, 8);
        fill_addresses(8'hff);
        send_packet(1'b0, 0);
        build_ipv4(5, 8'd1, 10);
        put16(2, 16'd19);
        send_packet(1'b0, 0);
        build_ipv4(5, PROTO_UDP, 8);
        put16(2, 16'd29);
        send_packet(1'b0, 0);
        build_ipv4(5, 8'hff, 4);
        fill_addresses(8'h00);
        send_packet(1'b0, 0);
    endtask

    task automatic test_fragments();
        build_ipv4(5, PROTO_TCP, 20);
        put16(6, FRAG_MF_BIT);
        send_packet(1'b0, 0);
        build_ipv4(5, PROTO_UDP, 8);
        put16(6, FRAG_OFS_MASK);
        send_packet(1'b0, 0);
    endtask

    task automatic test_tcp();
        build_ipv4(5, PROTO_TCP, 20);
        frame_bytes[20 + OFS_TOF_HI] = {4'd5, frame_bytes[20 + OFS_TOF_HI][3:0]};
        frame_bytes[20 + OFS_TOF_LO] = frame_bytes[20 + OFS_TOF_LO] | TCP_RST_BIT[7:0];
        put16(20 + OFS_SPORT_HI, 16'hffff);
        put16(20 + OFS_DPORT_HI, 16'h0000);
        send_packet(1'b0, 0);
        frame_bytes[20 + OFS_TOF_HI] = {4'd4, frame_bytes[20 + OFS_TOF_HI][3:0]};
        send_packet(1'b0, 0);
        build_ipv4(5, PROTO_TCP, 40);
        frame_bytes[20 + OFS_TOF_HI] = {4'd15, frame_bytes[20 + OFS_TOF_HI][3:0]};
        send_packet(1'b0, 0);
        build_ipv4(15, PROTO_TCP, 60);
        frame_bytes[60 + OFS_TOF_HI] = {4'd15, frame_bytes[60 + OFS_TOF_HI][3:0]};
        frame_bytes[60 + OFS_TOF_LO] = frame_bytes[60 + OFS_TOF_LO] & ~TCP_RST_BIT[7:0];
        send_packet(1'b0, 0);
        build_ipv4(5, PROTO_TCP, 19);
        send_packet(1'b0, 0);
    endtask

    task automatic test_udp();
        build_ipv4(5, PROTO_UDP, 8);
        put16(20 + OFS_ULEN_HI, 16'd8);
        put16(20 + OFS_SPORT_HI, 16'h0000);
        put16(20 + OFS_DPORT_HI, 16'hffff);
        send_packet(1'b0, 0);
        put16(20 + OFS_ULEN_HI, 16'd7);
        send_packet(1'b0, 0);
        build_ipv4(5, PROTO_UDP, 12);
        put16(20 + OFS_ULEN_HI, 16'd13);
        send_packet(1'b0, 0);
        build_ipv4(5, PROTO_UDP, 7);
        send_packet(1'b0, 0);
    endtask

    task automatic test_gso();
        build_ipv4(5, PROTO_TCP, 20);
        put16(2, 16'd0);
        send_packet(1'b1, 0);
        send_packet(1'b0, 0);
        put16(2, 16'd39);
        send_packet(1'b1, 6);
        build_ipv4(5, PROTO_UDP, 8);
        put16(2, 16'd0);
        send_packet(1'b1, 0);
    endtask

    task automatic test_long_packets();
        build_ipv4(5, PROTO_TCP, 20);
        send_packet(1'b0, 100);
    endtask

    task automatic random_packet();
        int         kind;
        int         ihl;
        int         l4_len;
        int         hlen;
        int         extra;
        int         cut;
        int         pick;
        bit         gso;
        logic [7:0] proto;
        kind = $urandom_range(99);
        gso = 1'($urandom_range(1));
        extra = 0;
        if (kind < 8) begin
            build_raw($urandom_range(90, 1));
        end else if (kind < 18) begin
            build_raw($urandom_range(70, 36));
            set_version(VER_IPV6);
        end else begin
            pick = $urandom_range(99);
            ihl = (pick < 75) ? 5 : (pick < 95) ? $urandom_range(15, 6) : $urandom_range(4, 0);
            pick = $urandom_range(99);
            proto = (pick < 45) ? PROTO_TCP : (pick < 80) ? PROTO_UDP : 8'($urandom_range(255));
            if (proto == PROTO_TCP)
                l4_len = ($urandom_range(3) == 0) ? $urandom_range(40, 0) : $urandom_range(32, 20);
            else if (proto == PROTO_UDP)
                l4_len = ($urandom_range(3) == 0) ? $urandom_range(30, 0) : $urandom_range(24, 8);
            else
                l4_len = $urandom_range(24, 0);
            build_ipv4(ihl, proto, l4_len);
            hlen = ihl * 4;
            if ($urandom_range(99) < 8)
                put16(6, {frame_bytes[6], frame_bytes[7]}
                         | (16'($urandom_range(16'h3fff, 1)) & (FRAG_MF_BIT | FRAG_OFS_MASK)));
            if (proto == PROTO_TCP && gso && $urandom_range(1))
                put16(2, 16'($urandom_range(hlen + 19, 0)));
            if (proto == PROTO_TCP && l4_len >= TCP_MIN_HDR && $urandom_range(99) < 10)
                frame_bytes[hlen + OFS_TOF_HI] = 8'($urandom_range(255));
            if (proto == PROTO_UDP && l4_len >= UDP_MIN_HDR && $urandom_range(99) < 10)
                put16(hlen + OFS_ULEN_HI, 16'($urandom_range(16'hffff)));
            case ($urandom_range(9))
                0: frame_bytes[$urandom_range(frame_bytes.size() - 1)] = 8'($urandom_range(255));
                1: extra = $urandom_range(20, 1);
                2: begin
                    cut = $urandom_range(8, 1);
                    while (cut > 0 && frame_bytes.size() > 1) begin
                        void'(frame_bytes.pop_back());
                        cut--;
                    end
                end
                3: set_version(4'($urandom_range(15)));
                default: ;
            endcase
        end
        send_packet(gso, extra);
    endtask

    task automatic test_random_traffic();
        int n_pkts;
        n_pkts = 0;
        random_bytes_sent = 0;
        while (random_bytes_sent < RANDOM_BYTES || n_pkts < RANDOM_PACKETS) begin
            quiet = (n_pkts >= 4 && n_pkts < 10);
            if (n_pkts == 2) wait_for_verdicts();
            random_packet();
            n_pkts++;
        end
        quiet = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < HEADER_WINDOW; i++) header_copy[i] = 8'h00;
        byte_tally = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_short_packets();
        test_ipv6();
        test_ip_header();
        test_fragments();
        test_tcp();
        test_udp();
        test_gso();
        test_long_packets();
        test_random_traffic();
        wait_for_verdicts();
        repeat (20) @(posedge i_clk);
        if (n_errors == 0 && verdict_q.size() == 0) begin
            $display("tb_ipv4_l4_header_classifier passed");
        end else begin
            $display("tb_ipv4_l4_header_classifier failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ihc_pkg.sv
rtl/ipv4_l4_header_classifier.sv
rtl/ihc_checker.sv
bench/tb_ipv4_l4_header_classifier.sv
